// File: rtl/core/md5_pkg.sv
// md5 hasher package: item types, round constants, rotate and message index helpers
// no dependencies
package md5_pkg;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } md5_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } md5_rsp_type;

   localparam logic FUNC_APPEND   = 1'b0;
   localparam logic FUNC_FINALIZE = 1'b1;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } md5_state_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   // message word index per round
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] k;
      logic [3:0] l;
      l = i[3:0];
      case (i[5:4])
         2'd0:    k = l;
         2'd1:    k = 4'(5 * l + 1);
         2'd2:    k = 4'(3 * l + 5);
         default: k = 4'(7 * l);
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

endpackage

// File: rtl/core/md5_queue.sv
// small item queue between the front and back parts
// depends on md5_pkg
module md5_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  md5_pkg::md5_req_type push_item,
   output logic                full,
   input  logic                pop,
   output md5_pkg::md5_req_type pop_item,
   output logic                not_empty
);
   import md5_pkg::*;

   md5_req_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]    cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   assign pop_item  = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !not_empty |-> !pop)
      else $error("queue pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance");
endmodule

// File: rtl/core/md5_engine.sv
// back part: block gathering, padding, 64-round compression, digest emission
// depends on md5_pkg
module md5_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  md5_pkg::md5_req_type item,
   output logic                 item_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output md5_pkg::md5_rsp_type rsp_item
);
   import md5_pkg::*;

   // block store memory, one 32-bit word per entry, byte write enables
   logic [31:0]    blk_mem [16];
   logic [31:0]    chain_ff [4];
   logic [31:0]    a_ff, b_ff, c_ff, d_ff;
   logic [5:0]     fill_ff, fill_in;
   logic [60:0]    count_ff, count_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [5:0]     padpos_ff, padpos_in;
   logic           final_ff, final_in;
   logic [1:0]     emit_ff, emit_in;
   md5_state_type  st_ff, st_in;

   logic           wr_en;
   logic [5:0]     wr_addr;
   logic [7:0]     wr_byte;
   logic [31:0]    w_rd;
   logic [63:0]    bits;
   logic [31:0]    fval, tsum;
   logic           round_start, add_done;

   assign bits = {count_ff, 3'b000};

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               // marker in the last byte fills the block, compress it right away
               if (item.func == FUNC_FINALIZE)
                  st_in = (fill_ff == 6'd63) ? ST_ROUND : ST_PAD;
               else if (fill_ff == 6'd63) st_in = ST_ROUND;
            end
         end
         ST_PAD: begin
            if (padpos_ff == 6'd63) st_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) st_in = ST_ADD;
         end
         ST_ADD: begin
            // fill 63 on a finalize marks a second block of zeros and length
            if (!final_ff) st_in = ST_IDLE;
            else if (fill_ff == 6'd63) st_in = ST_PAD;
            else st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall && emit_ff == 2'd3) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // control outputs and data path selection
   always_comb begin
      item_pop    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = padpos_ff;
      wr_byte     = 8'h00;
      fill_in     = fill_ff;
      count_in    = count_ff;
      padpos_in   = padpos_ff;
      final_in    = final_ff;
      emit_in     = emit_ff;
      rnd_in      = 6'd0;
      round_start = 1'b0;
      add_done    = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               wr_en    = 1'b1;
               wr_addr  = fill_ff;
               if (item.func == FUNC_APPEND) begin
                  wr_byte  = item.data_byte;
                  fill_in  = fill_ff + 1'b1;
                  count_in = count_ff + 61'd1;
                  round_start = (fill_ff == 6'd63);
               end else begin
                  // pad marker, then zeros and length
                  wr_byte   = 8'h80;
                  final_in  = 1'b1;
                  padpos_in = fill_ff + 1'b1;
                  round_start = (fill_ff == 6'd63);
               end
            end
         end
         ST_PAD: begin
            wr_en   = 1'b1;
            wr_addr = padpos_ff;
            if (padpos_ff >= 6'd56 && fill_ff <= 6'd55)
               wr_byte = bits[8*padpos_ff[2:0] +: 8];
            padpos_in = padpos_ff + 1'b1;
            if (padpos_ff == 6'd63) begin
               round_start = 1'b1;
               // a second block is needed when the marker passed byte 55
               fill_in = (fill_ff <= 6'd55) ? 6'd0 : 6'd63;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 1'b1;
         end
         ST_ADD: begin
            add_done = 1'b1;
            if (final_ff) begin
               // second pass pads from byte zero with length
               if (fill_ff == 6'd63) begin
                  fill_in   = 6'd0;
                  padpos_in = 6'd0;
               end
               if (padpos_ff == 6'd0 && fill_ff == 6'd63) padpos_in = 6'd0;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               emit_in = emit_ff + 1'b1;
               if (emit_ff == 2'd3) begin
                  final_in  = 1'b0;
                  fill_in   = 6'd0;
                  count_in  = '0;
                  padpos_in = 6'd0;
               end
            end
         end
         default: ;
      endcase
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         fill_ff   <= '0;
         count_ff  <= '0;
         rnd_ff    <= '0;
         padpos_ff <= '0;
         final_ff  <= 1'b0;
         emit_ff   <= '0;
      end else begin
         st_ff     <= st_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         rnd_ff    <= rnd_in;
         padpos_ff <= padpos_in;
         final_ff  <= final_in;
         emit_ff   <= emit_in;
      end
   end

   // block memory: byte write, word read registered for the next round
   logic [5:0] rd_rnd;
   assign rd_rnd = (st_ff == ST_ROUND) ? rnd_ff + 1'b1 : 6'd0;
   always_ff @(posedge clock) begin
      if (wr_en) blk_mem[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_byte;
      w_rd <= blk_mem[msg_index(rd_rnd)];
   end

   // round function
   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0:    fval = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    fval = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    fval = b_ff ^ c_ff ^ d_ff;
         default: fval = c_ff ^ (b_ff | ~d_ff);
      endcase
      tsum = fval + a_ff + round_const(rnd_ff) + w_rd;
   end

   // working and chaining words
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
      end else if (add_done) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
      end else if (st_ff == ST_EMIT && !rsp_stall && emit_ff == 2'd3) begin
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
      end
   end

   always_ff @(posedge clock) begin
      if (round_start) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (st_ff == ST_ROUND) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rotl(tsum, rot_amount(rnd_ff));
      end
   end

   assign rsp_valid            = (st_ff == ST_EMIT);
   assign rsp_item.digest_word = chain_ff[emit_ff];
   assign rsp_item.word_index  = emit_ff;
   assign rsp_item.last_word   = (emit_ff == 2'd3);

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (st_ff == ST_IDLE)) else $error("item taken while busy");
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && emit_ff != 2'd3) |=> (st_ff == ST_EMIT))
      else $error("digest emission cut short");
   a_round_len: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_ROUND && rnd_ff == 6'd63) |=> (st_ff == ST_ADD))
      else $error("round sequence broken");
endmodule

// File: rtl/core/md5_stream_hasher.sv
// md5 stream hasher top level: input queue in front of the hashing engine
// depends on md5_pkg, md5_queue, md5_engine
//
// One message byte per item (func 0); a finalize item (func 1) pads the
// message, appends the bit length and returns the four digest words, word
// index 0 to 3, the last flagged. Bytes are queued and written into the
// block store one per cycle while the engine is idle; the 64th byte of a
// block starts 64 rounds on one shared round unit, and input stalls once
// the four-entry queue fills. A finalize pads, runs the rounds and updates
// the chain, twice when the marker lands past byte 55 and a second block
// is needed, then hands out the digest.
module md5_stream_hasher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  md5_pkg::md5_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output md5_pkg::md5_rsp_type rsp_item
);
   import md5_pkg::*;

   md5_req_type q_item;
   logic        q_full, q_ne, q_pop;

   // front queue
   md5_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_valid && !q_full), .push_item(req_item), .full(q_full),
      .pop(q_pop), .pop_item(q_item), .not_empty(q_ne)
   );

   assign req_stall = q_full;

   // back engine
   md5_engine u_engine (
      .clock(clock), .reset(reset),
      .item_valid(q_ne), .item(q_item), .item_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );
endmodule
